// ===== rtl/lru_size_budget_cache_directory_unit_defines.svh =====
`ifndef LRU_SIZE_BUDGET_CACHE_DIRECTORY_UNIT_DEFINES_SVH
`define LRU_SIZE_BUDGET_CACHE_DIRECTORY_UNIT_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define LSBCD_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define LSBCD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/lsbcd_pkg.sv =====
`default_nettype none

package lsbcd_pkg;

  // Default table depth.
  localparam int DEFAULT_ENTRIES = 16;

  // Field widths.
  localparam int ID_W    = 32;
  localparam int SIZE_W  = 32;
  localparam int STAMP_W = 48;
  localparam int LIMIT_W = 5;

  // Reset values.
  localparam logic [SIZE_W-1:0]  BUDGET_RESET = 32'd1048576;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET  = 5'd16;
  localparam logic [ID_W-1:0]    ID_RESET     = 32'd1;

  // Result kinds.
  typedef enum logic [2:0] {
    KIND_EVICTED   = 3'd0,
    KIND_ADDED     = 3'd1,
    KIND_HIT       = 3'd2,
    KIND_MISS      = 3'd3,
    KIND_TOO_LARGE = 3'd4
  } kind_t;

  // Request kinds.
  typedef enum logic [0:0] {
    FUNC_ADD = 1'b0,
    FUNC_GET = 1'b1
  } func_t;

  // Configuration register indexes.
  typedef enum logic [0:0] {
    CFG_BYTE_BUDGET = 1'b0,
    CFG_ENTRY_LIMIT = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    func_t              func;
    logic [SIZE_W-1:0]  object_size;
    logic [ID_W-1:0]    lookup_id;
  } req_t;

  typedef struct packed {
    kind_t              kind;
    logic [ID_W-1:0]    entry_id;
    logic [SIZE_W-1:0]  entry_size;
    logic               last;
  } result_t;

  // One table entry as stored in the directory memory.
  typedef struct packed {
    logic [ID_W-1:0]    id;
    logic [SIZE_W-1:0]  size;
    logic [STAMP_W-1:0] stamp;
  } entry_t;

  // Datapath operations; every one but OP_NONE emits one result and may change state.
  typedef enum logic [2:0] {
    OP_NONE,
    OP_EVICT,
    OP_ADD,
    OP_HIT,
    OP_MISS,
    OP_TOO_LARGE
  } op_t;

  typedef struct packed {
    logic load;        // capture the request
    logic scan_start;  // begin a pass over the table
    logic next_id;     // advance the id candidate
    op_t  op;
  } ctrl_cmd_t;

  typedef struct packed {
    logic scan_done;   // last entry of the pass is being evaluated
    logic is_get;
    logic too_large;
    logic need_evict;
    logic has_entries;
    logic match;       // target id found by the finished pass
  } ctrl_status_t;

endpackage

`default_nettype wire

// ===== rtl/lsbcd_ctrl.sv =====
`default_nettype none

module lsbcd_ctrl (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    start,
  input  wire lsbcd_pkg::ctrl_status_t status,
  output lsbcd_pkg::ctrl_cmd_t         cmd,
  output logic                         busy
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_CHECK,
    ST_EVICT_SCAN,
    ST_EVICT,
    ST_ALLOC_SCAN,
    ST_ALLOC_DECIDE,
    ST_GET_SCAN,
    ST_GET_DECIDE
  } state_t;

  state_t state;
  state_t state_next;

  // Sequencing of one request through scans and result transactions.
  always_comb begin
    state_next     = state;
    cmd.load       = 1'b0;
    cmd.scan_start = 1'b0;
    cmd.next_id    = 1'b0;
    cmd.op         = lsbcd_pkg::OP_NONE;
    case (state)
      ST_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (status.is_get) begin
          cmd.scan_start = 1'b1;
          state_next     = ST_GET_SCAN;
        end else if (status.too_large) begin
          cmd.op     = lsbcd_pkg::OP_TOO_LARGE;
          state_next = ST_IDLE;
        end else begin
          state_next = ST_CHECK;
        end
      end
      ST_CHECK: begin
        // Keep evicting while either limit is exceeded and something is left.
        cmd.scan_start = 1'b1;
        if (status.need_evict && status.has_entries) begin
          state_next = ST_EVICT_SCAN;
        end else begin
          cmd.next_id = 1'b1;
          state_next  = ST_ALLOC_SCAN;
        end
      end
      ST_EVICT_SCAN: begin
        if (status.scan_done) begin
          state_next = ST_EVICT;
        end
      end
      ST_EVICT: begin
        cmd.op     = lsbcd_pkg::OP_EVICT;
        state_next = ST_CHECK;
      end
      ST_ALLOC_SCAN: begin
        if (status.scan_done) begin
          state_next = ST_ALLOC_DECIDE;
        end
      end
      ST_ALLOC_DECIDE: begin
        // A candidate id in use is skipped and the next one is scanned.
        if (status.match) begin
          cmd.next_id    = 1'b1;
          cmd.scan_start = 1'b1;
          state_next     = ST_ALLOC_SCAN;
        end else begin
          cmd.op     = lsbcd_pkg::OP_ADD;
          state_next = ST_IDLE;
        end
      end
      ST_GET_SCAN: begin
        if (status.scan_done) begin
          state_next = ST_GET_DECIDE;
        end
      end
      ST_GET_DECIDE: begin
        cmd.op     = status.match ? lsbcd_pkg::OP_HIT : lsbcd_pkg::OP_MISS;
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != ST_IDLE);

endmodule

`default_nettype wire

// ===== rtl/lsbcd_datapath.sv =====
`default_nettype none

module lsbcd_datapath #(
  parameter int ENTRIES = lsbcd_pkg::DEFAULT_ENTRIES
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire lsbcd_pkg::ctrl_cmd_t                 cmd,
  input  wire lsbcd_pkg::req_t                      req,
  input  wire logic                                 cfg_write,
  input  wire lsbcd_pkg::cfg_reg_t                  cfg_index,
  input  wire logic [lsbcd_pkg::SIZE_W-1:0]         cfg_data,
  output lsbcd_pkg::ctrl_status_t                   status,
  output logic                                      result_valid,
  output lsbcd_pkg::result_t                        result
);

  localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CW = $clog2(ENTRIES + 1);
  localparam int LW = (CW > lsbcd_pkg::LIMIT_W) ? CW : lsbcd_pkg::LIMIT_W;
  localparam logic [AW-1:0] LAST_IDX = AW'(ENTRIES - 1);

  // Configuration registers.
  logic [lsbcd_pkg::SIZE_W-1:0]  byte_budget;
  logic [lsbcd_pkg::LIMIT_W-1:0] entry_limit;

  // Request and allocation registers.
  lsbcd_pkg::req_t               req_q;
  logic [lsbcd_pkg::ID_W-1:0]    target_id;
  logic [lsbcd_pkg::ID_W-1:0]    previous_id;

  // Directory state.
  lsbcd_pkg::entry_t             mem [ENTRIES];
  logic [ENTRIES-1:0]            slot_valid;
  logic [CW-1:0]                 valid_count;
  logic [lsbcd_pkg::SIZE_W-1:0]  bytes_in_use;
  logic [lsbcd_pkg::STAMP_W-1:0] use_clock;

  // Scan pipeline.
  logic                          scan_issue;
  logic [AW-1:0]                 scan_addr;
  logic                          rd_vld;
  logic [AW-1:0]                 rd_idx;
  lsbcd_pkg::entry_t             rd_entry;
  logic                          rd_valid_bit;

  // Scan results.
  logic                          match_found;
  logic [AW-1:0]                 match_idx;
  logic [lsbcd_pkg::SIZE_W-1:0]  match_size;
  logic                          best_found;
  logic [AW-1:0]                 best_idx;
  lsbcd_pkg::entry_t             best_entry;
  logic                          free_found;
  logic [AW-1:0]                 free_idx;

  // Memory write port.
  logic                          mem_we;
  logic [AW-1:0]                 mem_wa;
  lsbcd_pkg::entry_t             mem_wd;

  logic [LW-1:0]                 limit_ext;
  logic [LW-1:0]                 limit_eff;
  logic                          over_bytes;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_budget <= lsbcd_pkg::BUDGET_RESET;
      entry_limit <= lsbcd_pkg::LIMIT_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        lsbcd_pkg::CFG_BYTE_BUDGET: byte_budget <= cfg_data;
        lsbcd_pkg::CFG_ENTRY_LIMIT: entry_limit <= cfg_data[lsbcd_pkg::LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  // Request capture and id candidate.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_q     <= req;
      target_id <= req.lookup_id;
    end else if (cmd.next_id) begin
      target_id <= previous_id + lsbcd_pkg::ID_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      previous_id <= lsbcd_pkg::ID_RESET;
    end else if (cmd.next_id) begin
      previous_id <= previous_id + lsbcd_pkg::ID_W'(1);
    end
  end

  // Scan address sequencing: one entry read per cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_issue <= 1'b0;
      rd_vld     <= 1'b0;
    end else begin
      rd_vld <= scan_issue;
      if (cmd.scan_start) begin
        scan_issue <= 1'b1;
      end else if (scan_issue && (scan_addr == LAST_IDX)) begin
        scan_issue <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_start) begin
      scan_addr <= '0;
    end else if (scan_issue && (scan_addr != LAST_IDX)) begin
      scan_addr <= scan_addr + AW'(1);
    end
    rd_idx       <= scan_addr;
    rd_valid_bit <= slot_valid[scan_addr];
  end

  // Directory memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_entry <= mem[scan_addr];
  end

  // Per-entry evaluation: first id match, oldest stamp, first free slot.
  always_ff @(posedge clk) begin
    if (cmd.scan_start) begin
      match_found <= 1'b0;
      best_found  <= 1'b0;
      free_found  <= 1'b0;
      free_idx    <= '0;
    end else if (rd_vld) begin
      if (rd_valid_bit && !match_found && (rd_entry.id == target_id)) begin
        match_found <= 1'b1;
        match_idx   <= rd_idx;
        match_size  <= rd_entry.size;
      end
      if (rd_valid_bit && (!best_found || (rd_entry.stamp < best_entry.stamp))) begin
        best_found <= 1'b1;
        best_idx   <= rd_idx;
        best_entry <= rd_entry;
      end
      if (!rd_valid_bit && !free_found) begin
        free_found <= 1'b1;
        free_idx   <= rd_idx;
      end
    end
  end

  // Memory write for a new entry or a refreshed stamp.
  always_comb begin
    mem_we = 1'b0;
    mem_wa = match_idx;
    mem_wd.id    = target_id;
    mem_wd.size  = match_size;
    mem_wd.stamp = use_clock;
    case (cmd.op)
      lsbcd_pkg::OP_ADD: begin
        mem_we      = 1'b1;
        mem_wa      = free_idx;
        mem_wd.id   = previous_id;
        mem_wd.size = req_q.object_size;
      end
      lsbcd_pkg::OP_HIT: begin
        mem_we = 1'b1;
      end
      default: ;
    endcase
  end

  // Valid bits, entry count, byte total and use clock.
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid   <= '0;
      valid_count  <= '0;
      bytes_in_use <= '0;
      use_clock    <= '0;
    end else begin
      case (cmd.op)
        lsbcd_pkg::OP_EVICT: begin
          slot_valid[best_idx] <= 1'b0;
          valid_count          <= valid_count - CW'(1);
          bytes_in_use         <= bytes_in_use - best_entry.size;
        end
        lsbcd_pkg::OP_ADD: begin
          slot_valid[free_idx] <= 1'b1;
          valid_count          <= valid_count + CW'(1);
          bytes_in_use         <= bytes_in_use + req_q.object_size;
          use_clock            <= use_clock + lsbcd_pkg::STAMP_W'(1);
        end
        lsbcd_pkg::OP_HIT: begin
          use_clock <= use_clock + lsbcd_pkg::STAMP_W'(1);
        end
        default: ;
      endcase
    end
  end

  // Result register: one transaction per operation.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= (cmd.op != lsbcd_pkg::OP_NONE);
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      lsbcd_pkg::OP_EVICT: begin
        result <= '{lsbcd_pkg::KIND_EVICTED, best_entry.id, best_entry.size, 1'b0};
      end
      lsbcd_pkg::OP_ADD: begin
        result <= '{lsbcd_pkg::KIND_ADDED, previous_id, req_q.object_size, 1'b1};
      end
      lsbcd_pkg::OP_HIT: begin
        result <= '{lsbcd_pkg::KIND_HIT, target_id, match_size, 1'b1};
      end
      lsbcd_pkg::OP_MISS: begin
        result <= '{lsbcd_pkg::KIND_MISS, target_id, '0, 1'b1};
      end
      lsbcd_pkg::OP_TOO_LARGE: begin
        result <= '{lsbcd_pkg::KIND_TOO_LARGE, '0, '0, 1'b1};
      end
      default: ;
    endcase
  end

  // Effective entry limit: zero acts as one, above the depth acts as the depth.
  always_comb begin
    limit_ext = LW'(entry_limit);
    if (limit_ext == '0) begin
      limit_eff = LW'(1);
    end else if (limit_ext > LW'(ENTRIES)) begin
      limit_eff = LW'(ENTRIES);
    end else begin
      limit_eff = limit_ext;
    end
  end

  assign over_bytes = ({1'b0, bytes_in_use} + {1'b0, req_q.object_size}) >
                      {1'b0, byte_budget};

  // Status toward the controller.
  always_comb begin
    status.scan_done   = rd_vld && (rd_idx == LAST_IDX);
    status.is_get      = (req_q.func == lsbcd_pkg::FUNC_GET);
    status.too_large   = (req_q.object_size > byte_budget);
    status.need_evict  = over_bytes || (LW'(valid_count) >= limit_eff);
    status.has_entries = (valid_count != '0);
    status.match       = match_found;
  end

endmodule

`default_nettype wire

// ===== rtl/lru_size_budget_cache_directory_unit.sv =====
// LRU directory for a cache of variable-sized objects, limited by a byte
// budget and an entry count.
// Requests: start with req (func, object_size, lookup_id) is taken when busy
// is low. Results appear on result for exactly one cycle with result_valid
// high; result.last marks the final result of a request. The receiver
// cannot stall, so each result is taken in the cycle it is shown.
// Configuration: cfg_valid/cfg_ready with cfg_index and cfg_data; cfg_ready
// is always high. Write only while busy is low and no result is pending.
// Operation: every table pass reads one entry per cycle from the directory
// memory. A get takes one pass; an add takes one pass per eviction and one
// per id candidate tried; a too-large add answers without a pass. One request
// is in work at a time.
// Reset (rst, synchronous): the table is empty, the byte total and use
// clock are zero, the id counter is one, and the registers return to a
// budget of 1048576 bytes and a limit of 16 entries.
`default_nettype none

module lru_size_budget_cache_directory_unit #(
  parameter int ENTRIES = lsbcd_pkg::DEFAULT_ENTRIES
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  output logic                               busy,
  input  wire lsbcd_pkg::req_t               req,
  output logic                               result_valid,
  output lsbcd_pkg::result_t                 result,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire lsbcd_pkg::cfg_reg_t           cfg_index,
  input  wire logic [lsbcd_pkg::SIZE_W-1:0]  cfg_data
);

  lsbcd_pkg::ctrl_cmd_t    cmd;
  lsbcd_pkg::ctrl_status_t status;

  // Configuration writes are taken in any cycle.
  assign cfg_ready = 1'b1;

  lsbcd_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy)
  );

  lsbcd_datapath #(
    .ENTRIES (ENTRIES)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .req          (req),
    .cfg_write    (cfg_valid && cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .status       (status),
    .result_valid (result_valid),
    .result       (result)
  );

endmodule

`default_nettype wire

// ===== rtl/lsbcd_checker.sv =====
`default_nettype none

`include "lru_size_budget_cache_directory_unit_defines.svh"

module lsbcd_checker (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               start,
  input wire logic               busy,
  input wire logic               result_valid,
  input wire lsbcd_pkg::result_t result
);

  // An accepted request keeps the block busy in the following cycle.
  `LSBCD_ASSERT_NEXT(a_accept_busy, clk, rst, start && !busy, busy, "accepted request not busy")

  // More results follow a result that is not the final one.
  `LSBCD_ASSERT_NOW(a_more_busy, clk, rst, result_valid && !result.last, busy, "idle mid request")

  // The final result of a request is never directly followed by another.
  `LSBCD_ASSERT_NEXT(a_last_gap, clk, rst, result_valid && result.last, !result_valid, "result after last")

  // Only eviction results leave the request open.
  `LSBCD_ASSERT_NOW(a_kind_last, clk, rst, result_valid && (result.kind != lsbcd_pkg::KIND_EVICTED), result.last, "non-eviction result not last")

endmodule

bind lru_size_budget_cache_directory_unit lsbcd_checker u_checker (.*);

`default_nettype wire

// ===== bench/tb_lru_size_budget_cache_directory_unit.sv =====
`timescale 1ns / 100ps

module tb_lru_size_budget_cache_directory_unit;
  import lsbcd_pkg::*;

  localparam int DEPTH           = 16;
  localparam int CYCLE_LIMIT     = 500000;
  localparam int PHASES          = 4;
  localparam int ITEMS_PER_PHASE = 28;

  logic               clk = 1'b0;
  logic               rst;
  logic               start;
  logic               busy;
  req_t               req;
  logic               result_valid;
  result_t            result;
  logic               cfg_valid;
  logic               cfg_ready;
  cfg_reg_t           cfg_index;
  logic [SIZE_W-1:0]  cfg_data;

  lru_size_budget_cache_directory_unit #(
    .ENTRIES (DEPTH)
  ) u_top (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .req          (req),
    .result_valid (result_valid),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #10 clk = ~clk;

  // One row of the directed sequence: either a register write or a request,
  // the latter optionally with its single result written out by hand.
  typedef struct {
    bit                is_write;
    cfg_reg_t          reg_sel;
    logic [SIZE_W-1:0] value;
    req_t              rq;
    bit                typed;
    result_t           want;
  } plan_row_t;

  plan_row_t directed_plan[$];

  // Mirror of the directory contents and its settings.
  logic               held_valid [DEPTH];
  logic [ID_W-1:0]    held_id    [DEPTH];
  logic [SIZE_W-1:0]  held_size  [DEPTH];
  logic [STAMP_W-1:0] held_stamp [DEPTH];
  logic [STAMP_W-1:0] stamp_now;
  logic [ID_W-1:0]    id_counter;
  logic [SIZE_W-1:0]  bytes_held;
  logic [SIZE_W-1:0]  budget_setting;
  logic [LIMIT_W-1:0] limit_setting;

  result_t fresh_results[$];
  result_t pending_results[$];

  bit calm = 1'b0;
  int errors = 0;
  int requests_done = 0;
  int results_seen = 0;
  int evictions_seen = 0;
  int hits_seen = 0;
  int misses_seen = 0;
  int rejects_seen = 0;
  int cycle_count = 0;

  task automatic flag(input string what);
    errors++;
    $display("[%0t] mismatch: %s", $time, what);
  endtask

  // Slot that holds the given id, or -1 when it is not stored.
  function automatic int slot_holding(input logic [ID_W-1:0] id);
    for (int i = 0; i < DEPTH; i++) begin
      if (held_valid[i] && held_id[i] == id) return i;
    end
    return -1;
  endfunction

  // Work out the results of one request and advance the mirrored state.
  function automatic void predict_directory(input req_t r);
    int      slot;
    int      count;
    int      victim;
    int      cap;
    result_t one;
    fresh_results.delete();
    if (r.func == FUNC_GET) begin
      slot = slot_holding(r.lookup_id);
      if (slot < 0) begin
        one = '{kind: KIND_MISS, entry_id: r.lookup_id, entry_size: '0, last: 1'b1};
      end else begin
        held_stamp[slot] = stamp_now;
        stamp_now = stamp_now + 1'b1;
        one = '{kind: KIND_HIT, entry_id: r.lookup_id, entry_size: held_size[slot],
                last: 1'b1};
      end
      fresh_results = {fresh_results, one};
    end else if (r.object_size > budget_setting) begin
      one = '{kind: KIND_TOO_LARGE, entry_id: '0, entry_size: '0, last: 1'b1};
      fresh_results = {fresh_results, one};
    end else begin
      // An out-of-range limit is clamped to the table depth range.
      cap = (limit_setting == 0) ? 1 : (limit_setting > DEPTH) ? DEPTH : int'(limit_setting);
      // Evict the oldest entry until both the byte total and the count fit.
      while (1'b1) begin
        count = 0;
        victim = -1;
        for (int i = 0; i < DEPTH; i++) begin
          if (held_valid[i]) begin
            count++;
            if (victim < 0 || held_stamp[i] < held_stamp[victim]) victim = i;
          end
        end
        if ({1'b0, bytes_held} + {1'b0, r.object_size} <= {1'b0, budget_setting} &&
            count + 1 <= cap) break;
        if (victim < 0) break;
        held_valid[victim] = 1'b0;
        bytes_held = bytes_held - held_size[victim];
        one = '{kind: KIND_EVICTED, entry_id: held_id[victim],
                entry_size: held_size[victim], last: 1'b0};
        fresh_results = {fresh_results, one};
      end
      // The next id skips any that is still stored.
      do begin
        id_counter = id_counter + 1'b1;
      end while (slot_holding(id_counter) >= 0);
      slot = 0;
      while (slot < DEPTH && held_valid[slot]) slot++;
      if (slot >= DEPTH) slot = 0;
      held_valid[slot] = 1'b1;
      held_id[slot]    = id_counter;
      held_size[slot]  = r.object_size;
      held_stamp[slot] = stamp_now;
      bytes_held = bytes_held + r.object_size;
      stamp_now = stamp_now + 1'b1;
      one = '{kind: KIND_ADDED, entry_id: id_counter, entry_size: r.object_size, last: 1'b1};
      fresh_results = {fresh_results, one};
    end
  endfunction

  task automatic plan_request(input func_t f, input logic [SIZE_W-1:0] size,
                              input logic [ID_W-1:0] id);
    plan_row_t row;
    row = '{is_write: 1'b0, reg_sel: CFG_BYTE_BUDGET, value: '0,
            rq: '{func: f, object_size: size, lookup_id: id}, typed: 1'b0, want: '0};
    directed_plan = {directed_plan, row};
  endtask

  task automatic plan_answer(input func_t f, input logic [SIZE_W-1:0] size,
                             input logic [ID_W-1:0] id, input kind_t k,
                             input logic [ID_W-1:0] want_id,
                             input logic [SIZE_W-1:0] want_size);
    plan_row_t row;
    row = '{is_write: 1'b0, reg_sel: CFG_BYTE_BUDGET, value: '0,
            rq: '{func: f, object_size: size, lookup_id: id}, typed: 1'b1,
            want: '{kind: k, entry_id: want_id, entry_size: want_size, last: 1'b1}};
    directed_plan = {directed_plan, row};
  endtask

  task automatic plan_write(input cfg_reg_t sel, input logic [SIZE_W-1:0] value);
    plan_row_t row;
    row = '{is_write: 1'b1, reg_sel: sel, value: value, rq: '0, typed: 1'b0, want: '0};
    directed_plan = {directed_plan, row};
  endtask

  // Hold off new requests until every expected result has come back.
  task automatic drain();
    start <= 1'b0;
    while (pending_results.size() != 0 || busy) @(posedge clk);
  endtask

  // Register writes only happen with the block idle.
  task automatic write_register(input cfg_reg_t sel, input logic [SIZE_W-1:0] value);
    drain();
    repeat (4) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= sel;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (sel == CFG_BYTE_BUDGET) budget_setting = value;
    else limit_setting = value[LIMIT_W-1:0];
  endtask

  // Present one request and wait for the transaction; start stays high after.
  task automatic issue(input req_t r, input bit typed, input result_t want);
    start <= 1'b1;
    req   <= r;
    do @(posedge clk); while (busy);
    requests_done++;
    predict_directory(r);
    if (typed) pending_results = {pending_results, want};
    else pending_results = {pending_results, fresh_results};
  endtask

  task automatic sender_gap();
    if (!calm && $urandom_range(3, 0) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(3, 1)) @(posedge clk);
    end
  endtask

  // Mostly adds sized against the budget and gets of stored ids, plus noise.
  function automatic req_t make_request();
    req_t r;
    int   stored[$];
    int   roll;
    roll = $urandom_range(99, 0);
    r.object_size = $urandom;
    r.lookup_id   = $urandom;
    if (roll < 55) begin
      r.func = FUNC_ADD;
      if ($urandom_range(7, 0) != 0)
        r.object_size = $urandom_range(budget_setting / $urandom_range(6, 1));
    end else begin
      r.func = FUNC_GET;
      for (int i = 0; i < DEPTH; i++) begin
        if (held_valid[i]) stored = {stored, i};
      end
      if (roll < 85 && stored.size() != 0)
        r.lookup_id = held_id[stored[$urandom_range(stored.size() - 1, 0)]];
    end
    return r;
  endfunction

  // Compare each result with the oldest expectation.
  always @(posedge clk) begin : result_check
    result_t want;
    if (!rst && result_valid) begin
      results_seen++;
      case (result.kind)
        KIND_EVICTED:   evictions_seen++;
        KIND_HIT:       hits_seen++;
        KIND_MISS:      misses_seen++;
        KIND_TOO_LARGE: rejects_seen++;
        default: ;
      endcase
      if (pending_results.size() == 0) begin
        flag($sformatf("result kind %0d id %0h with nothing expected", result.kind,
                       result.entry_id));
      end else begin
        want = pending_results.pop_front();
        if (result.kind !== want.kind)
          flag($sformatf("kind %0d, expected %0d", result.kind, want.kind));
        if (result.entry_id !== want.entry_id)
          flag($sformatf("entry_id %0h, expected %0h", result.entry_id, want.entry_id));
        if (result.entry_size !== want.entry_size)
          flag($sformatf("entry_size %0h, expected %0h", result.entry_size,
                         want.entry_size));
        if (result.last !== want.last)
          flag($sformatf("last %0b, expected %0b", result.last, want.last));
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               pending_results.size());
      $display("tb_lru_size_budget_cache_directory_unit: errors");
      $finish;
    end
  end

  initial begin : stimulus
    req_t r;
    rst       = 1'b1;
    start     = 1'b0;
    req       = '0;
    cfg_valid = 1'b0;
    cfg_index = CFG_BYTE_BUDGET;
    cfg_data  = '0;
    foreach (held_valid[i]) begin
      held_valid[i] = 1'b0;
      held_id[i]    = '0;
      held_size[i]  = '0;
      held_stamp[i] = '0;
    end
    stamp_now      = '0;
    id_counter     = ID_RESET;
    bytes_held     = '0;
    budget_setting = BUDGET_RESET;
    limit_setting  = LIMIT_RESET;

    // Reset state: misses, the budget edge on both sides, first ids.
    plan_answer(FUNC_GET, 32'h0, 32'd5, KIND_MISS, 32'd5, 32'h0);
    plan_answer(FUNC_GET, 32'h0, 32'h0, KIND_MISS, 32'h0, 32'h0);
    plan_answer(FUNC_GET, 32'hFFFF_FFFF, 32'hFFFF_FFFF, KIND_MISS, 32'hFFFF_FFFF, 32'h0);
    plan_answer(FUNC_ADD, 32'h0010_0001, 32'h0, KIND_TOO_LARGE, 32'h0, 32'h0);
    plan_answer(FUNC_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, KIND_TOO_LARGE, 32'h0, 32'h0);
    plan_answer(FUNC_ADD, 32'h0, 32'h0, KIND_ADDED, 32'd2, 32'h0);
    plan_answer(FUNC_ADD, 32'h0010_0000, 32'h0, KIND_ADDED, 32'd3, 32'h0010_0000);
    plan_answer(FUNC_GET, 32'h0, 32'd2, KIND_HIT, 32'd2, 32'h0);
    plan_request(FUNC_ADD, 32'd1, 32'hFFFF_FFFF);
    // Largest budget with a largest object: evicts everything else.
    plan_write(CFG_BYTE_BUDGET, 32'hFFFF_FFFF);
    plan_request(FUNC_ADD, 32'hFFFF_FFFF, 32'h0);
    plan_request(FUNC_ADD, 32'h0, 32'h0);
    // A limit of zero behaves as one; one above the depth behaves as the depth.
    plan_write(CFG_ENTRY_LIMIT, 32'd0);
    plan_request(FUNC_ADD, 32'd7, 32'h0);
    plan_write(CFG_ENTRY_LIMIT, 32'd31);
    plan_write(CFG_BYTE_BUDGET, 32'h0);
    plan_answer(FUNC_ADD, 32'd1, 32'h0, KIND_TOO_LARGE, 32'h0, 32'h0);
    plan_request(FUNC_ADD, 32'h0, 32'h0);
    // Budget raised, three adds, then the budget lowered below the stored total and an add.
    plan_write(CFG_BYTE_BUDGET, 32'h0010_0000);
    plan_request(FUNC_ADD, 32'd3000, 32'h0);
    plan_request(FUNC_ADD, 32'd5000, 32'h0);
    plan_request(FUNC_ADD, 32'd200, 32'h0);
    plan_write(CFG_BYTE_BUDGET, 32'd4000);
    plan_request(FUNC_ADD, 32'd100, 32'h0);
    plan_request(FUNC_GET, 32'h0, 32'd11);
    plan_request(FUNC_GET, 32'h0, 32'd7);

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_plan[i]) begin
      if (directed_plan[i].is_write) begin
        write_register(directed_plan[i].reg_sel, directed_plan[i].value);
      end else begin
        issue(directed_plan[i].rq, directed_plan[i].typed, directed_plan[i].want);
        sender_gap();
      end
    end

    // Random phases, each under its own settings; the last runs without gaps.
    for (int p = 0; p < PHASES; p++) begin
      calm = (p == PHASES - 1);
      case (p)
        0: begin
          write_register(CFG_BYTE_BUDGET, 32'hFFFF_FFFF);
          write_register(CFG_ENTRY_LIMIT, 32'd16);
        end
        1: begin
          write_register(CFG_BYTE_BUDGET, $urandom_range(6000, 2000));
          write_register(CFG_ENTRY_LIMIT, $urandom_range(16, 3));
        end
        2: begin
          write_register(CFG_BYTE_BUDGET, 32'h0010_0000);
          write_register(CFG_ENTRY_LIMIT, 32'd1);
        end
        default: begin
          write_register(CFG_BYTE_BUDGET, $urandom);
          write_register(CFG_ENTRY_LIMIT, $urandom_range(31, 0));
        end
      endcase
      for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
        if (p == 1 && k == ITEMS_PER_PHASE / 2) drain();
        r = make_request();
        issue(r, 1'b0, '0);
        sender_gap();
      end
    end

    drain();
    repeat (4 * DEPTH) @(posedge clk);
    $display("Sent %0d requests under several budget and limit settings.", requests_done);
    $display("Checked %0d results: %0d evictions, %0d hits, %0d misses, %0d rejections.",
             results_seen, evictions_seen, hits_seen, misses_seen, rejects_seen);
    if (errors == 0) begin
      $display("tb_lru_size_budget_cache_directory_unit: clean");
    end else begin
      $display("tb_lru_size_budget_cache_directory_unit: errors");
    end
    $finish;
  end

endmodule
